FILE: hw/rtl/wtsg_pkg.sv
package wtsg_pkg;

  localparam int COORD_BITS   = 20;
  localparam int CORDIC_ITERS = 16;

  localparam int AX_W       = COORD_BITS + 1;
  localparam int SQ_W       = 2 * AX_W + 1;
  localparam int SQRT_ITERS = AX_W + 1;
  localparam int LEN_W      = AX_W + 3;
  localparam int SCALE_W    = 24;
  localparam int STRIDE_W   = 12;
  localparam int P_W        = LEN_W + SCALE_W;
  localparam int HI_W       = P_W - 20;
  localparam int MM_W       = HI_W + 11;
  localparam int DVD_W      = MM_W + 2;
  localparam int DVS_W      = STRIDE_W + 1;
  localparam int CX_W       = COORD_BITS + 12;
  localparam int CALC_N     = (SQRT_ITERS > CORDIC_ITERS) ? SQRT_ITERS : CORDIC_ITERS;
  localparam int LOOP_MAX   = (CALC_N > DVD_W) ? CALC_N : DVD_W;
  localparam int CNT_W      = $clog2(LOOP_MAX);

  localparam logic [15:0] TURN_STRAIGHT_LIM = 16'd2731;
  localparam logic [15:0] TURN_SLIGHT_LIM   = 16'd8192;
  localparam logic [15:0] TURN_NORMAL_LIM   = 16'd24576;

  localparam logic [2:0] TC_HEAD     = 3'd0;
  localparam logic [2:0] TC_STRAIGHT = 3'd1;
  localparam logic [2:0] TC_SLIGHT_L = 3'd2;
  localparam logic [2:0] TC_SLIGHT_R = 3'd3;
  localparam logic [2:0] TC_LEFT     = 3'd4;
  localparam logic [2:0] TC_RIGHT    = 3'd5;
  localparam logic [2:0] TC_UTURN    = 3'd6;

  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_STRIDE = 1'b1;

  localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd65536;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 12'd700;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         route_end;
  } in_word_t;

  typedef struct packed {
    logic        seg_valid;
    logic [2:0]  turn_class;
    logic [15:0] seg_step_cnt;
    logic [27:0] seg_length_mm;
    logic [23:0] route_step_cnt;
    logic [31:0] total_length_mm;
    logic        is_last;
  } out_word_t;

  typedef struct packed {
    logic             load;
    logic             sq_x;
    logic             sq_y;
    logic             calc_step;
    logic             mul1;
    logic             mul2;
    logic             div_init;
    logic             div_step;
    logic             finish;
    logic             emit;
    logic [CNT_W-1:0] idx;
  } wtsg_cmd_t;

  typedef struct packed {
    logic seg;
    logic need_out;
  } wtsg_sts_t;

  function automatic logic [15:0] atan_turn(input logic [4:0] i);
    logic [15:0] a;
    case (i)
      5'd0:    a = 16'd8192;
      5'd1:    a = 16'd4836;
      5'd2:    a = 16'd2555;
      5'd3:    a = 16'd1297;
      5'd4:    a = 16'd651;
      5'd5:    a = 16'd326;
      5'd6:    a = 16'd163;
      5'd7:    a = 16'd81;
      5'd8:    a = 16'd41;
      5'd9:    a = 16'd20;
      5'd10:   a = 16'd10;
      5'd11:   a = 16'd5;
      5'd12:   a = 16'd3;
      5'd13:   a = 16'd1;
      5'd14:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/wtsg_datapath.sv
module wtsg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wtsg_pkg::wtsg_cmd_t             cmd,
  input  wtsg_pkg::in_word_t              in_word,
  input  logic [wtsg_pkg::SCALE_W-1:0]    map_scale,
  input  logic [wtsg_pkg::STRIDE_W-1:0]   step_length_mm,
  output wtsg_pkg::wtsg_sts_t             sts,
  output wtsg_pkg::out_word_t             res
);
  import wtsg_pkg::*;

  in_word_t                     word_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic                         have_prev_r, have_brg_r, seg_r, wide_r;
  logic [15:0]                  prev_brg_r;
  logic [23:0]                  sum_steps_r;
  logic [31:0]                  sum_len_r;
  logic signed [COORD_BITS:0]   dx_r, dy_r;
  logic [AX_W-1:0]              ax_r, ay_r;
  logic [SQ_W-1:0]              n_r, res_r, bit_r;
  logic signed [CX_W-1:0]       cx_r, cy_r;
  logic [15:0]                  z_r;
  logic [P_W-1:0]               p_r;
  logic [MM_W-1:0]              mm_r;
  logic [DVD_W-1:0]             dvd_r, q_r;
  logic [DVS_W-1:0]             rem_r;
  logic [2:0]                   tclass_r;
  logic [15:0]                  steps_r;
  logic [27:0]                  seglen_r;

  logic signed [COORD_BITS:0]   dx_c, dy_c;
  logic [AX_W-1:0]              ax_c, ay_c;
  logic [SQ_W-1:0]              t_c;
  logic signed [CX_W-1:0]       xe_c, ye_c, sx_c, sy_c;
  logic [LEN_W-1:0]             len_c;
  logic [HI_W+9:0]              hi_c;
  logic [30:0]                  lo_c;
  logic [STRIDE_W-1:0]          stride_c;
  logic [DVS_W-1:0]             dvs_c;
  logic [DVS_W:0]               rsh_c;
  logic [15:0]                  steps_c, d_c, ad_c;
  logic                         left_c;
  logic [2:0]                   tc_c;
  logic [24:0]                  ssum_c;
  logic [32:0]                  lsum_c;

  always_comb begin
    dx_c = {in_word.point_x[COORD_BITS-1], in_word.point_x} - {prev_x_r[COORD_BITS-1], prev_x_r};
    dy_c = {in_word.point_y[COORD_BITS-1], in_word.point_y} - {prev_y_r[COORD_BITS-1], prev_y_r};
    ax_c = dx_c[COORD_BITS] ? AX_W'(-dx_c) : AX_W'(dx_c);
    ay_c = dy_c[COORD_BITS] ? AX_W'(-dy_c) : AX_W'(dy_c);
    t_c  = res_r + bit_r;
    xe_c = {{(CX_W-COORD_BITS-9){dx_r[COORD_BITS]}}, dx_r, 8'b0};
    ye_c = {{(CX_W-COORD_BITS-9){dy_r[COORD_BITS]}}, dy_r, 8'b0};
    sx_c = cx_r >>> cmd.idx;
    sy_c = cy_r >>> cmd.idx;
    len_c = LEN_W'(res_r + SQ_W'(n_r > res_r)) << wide_r;
    hi_c = (HI_W+10)'(p_r[P_W-1:20]) * (HI_W+10)'(1000);
    lo_c = 31'(p_r[19:0]) * 31'd1000 + 31'd524288;
    stride_c = (step_length_mm == '0) ? STRIDE_W'(1) : step_length_mm;
    dvs_c = {stride_c, 1'b0};
    rsh_c = {rem_r, dvd_r[DVD_W-1]};
    if (q_r == '0) begin
      steps_c = 16'd1;
    end else if (q_r > DVD_W'(65535)) begin
      steps_c = 16'hFFFF;
    end else begin
      steps_c = q_r[15:0];
    end
    d_c    = z_r - prev_brg_r;
    left_c = (d_c != 16'd0) && !d_c[15];
    ad_c   = d_c[15] ? -d_c : d_c;
    if (!have_brg_r) begin
      tc_c = TC_HEAD;
    end else if (ad_c < TURN_STRAIGHT_LIM) begin
      tc_c = TC_STRAIGHT;
    end else if (ad_c < TURN_SLIGHT_LIM) begin
      tc_c = left_c ? TC_SLIGHT_L : TC_SLIGHT_R;
    end else if (ad_c < TURN_NORMAL_LIM) begin
      tc_c = left_c ? TC_LEFT : TC_RIGHT;
    end else begin
      tc_c = TC_UTURN;
    end
    ssum_c = {1'b0, sum_steps_r} + 25'(steps_r);
    lsum_c = {1'b0, sum_len_r} + 33'(seglen_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_word;
      dx_r   <= dx_c;
      dy_r   <= dy_c;
      wide_r <= |(ax_c >> 31) || |(ay_c >> 31);
      ax_r   <= ax_c >> (|(ax_c >> 31) || |(ay_c >> 31));
      ay_r   <= ay_c >> (|(ax_c >> 31) || |(ay_c >> 31));
    end
    if (cmd.sq_x) begin
      n_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
      if (dx_r[COORD_BITS]) begin
        cx_r <= -xe_c;
        cy_r <= -ye_c;
        z_r  <= 16'h8000;
      end else begin
        cx_r <= xe_c;
        cy_r <= ye_c;
        z_r  <= 16'h0000;
      end
    end
    if (cmd.sq_y) begin
      n_r   <= n_r + SQ_W'(ay_r) * SQ_W'(ay_r);
      res_r <= '0;
      bit_r <= SQ_W'(1) << (2 * (SQRT_ITERS - 1));
    end
    if (cmd.calc_step) begin
      if (cmd.idx < CNT_W'(SQRT_ITERS)) begin
        if (n_r >= t_c) begin
          n_r   <= n_r - t_c;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      if (cmd.idx < CNT_W'(CORDIC_ITERS)) begin
        if (!cy_r[CX_W-1] && (cy_r != '0)) begin
          cx_r <= cx_r + sy_c;
          cy_r <= cy_r - sx_c;
          z_r  <= z_r + atan_turn(5'(cmd.idx));
        end else begin
          cx_r <= cx_r - sy_c;
          cy_r <= cy_r + sx_c;
          z_r  <= z_r - atan_turn(5'(cmd.idx));
        end
      end
    end
    if (cmd.mul1) p_r <= P_W'(len_c) * P_W'(map_scale);
    if (cmd.mul2) mm_r <= MM_W'(hi_c) + MM_W'(lo_c[30:20]);
    if (cmd.div_init) begin
      dvd_r <= DVD_W'({mm_r, 1'b0}) + DVD_W'(stride_c);
      rem_r <= '0;
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rsh_c >= {1'b0, dvs_c}) begin
        rem_r <= DVS_W'(rsh_c - {1'b0, dvs_c});
        q_r   <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= DVS_W'(rsh_c);
        q_r   <= {q_r[DVD_W-2:0], 1'b0};
      end
      dvd_r <= dvd_r << 1;
    end
    if (cmd.finish) begin
      steps_r  <= steps_c;
      seglen_r <= 28'(28'(steps_c) * 28'(stride_c));
      tclass_r <= tc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      have_brg_r  <= 1'b0;
      seg_r       <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_brg_r  <= '0;
      sum_steps_r <= '0;
      sum_len_r   <= '0;
    end else begin
      if (cmd.load) begin
        seg_r <= have_prev_r && ((in_word.point_x != prev_x_r) || (in_word.point_y != prev_y_r));
      end
      // totals update as the word is emitted
      if (cmd.finish) begin
        prev_brg_r <= z_r;
        have_brg_r <= 1'b1;
      end
      if (cmd.emit) begin
        if (word_r.route_end) begin
          have_prev_r <= 1'b0;
          have_brg_r  <= 1'b0;
          prev_x_r    <= '0;
          prev_y_r    <= '0;
          prev_brg_r  <= '0;
          sum_steps_r <= '0;
          sum_len_r   <= '0;
        end else begin
          if (seg_r) begin
            sum_steps_r <= ssum_c[24] ? 24'hFFFFFF : ssum_c[23:0];
            sum_len_r   <= lsum_c[32] ? 32'hFFFFFFFF : lsum_c[31:0];
          end
          if (!have_prev_r || seg_r) begin
            prev_x_r    <= word_r.point_x;
            prev_y_r    <= word_r.point_y;
            have_prev_r <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    sts.seg      = seg_r;
    sts.need_out = seg_r || word_r.route_end;
    res.seg_valid       = seg_r;
    res.turn_class      = seg_r ? tclass_r : TC_HEAD;
    res.seg_step_cnt    = seg_r ? steps_r : 16'd0;
    res.seg_length_mm   = seg_r ? seglen_r : 28'd0;
    res.route_step_cnt  = !seg_r ? sum_steps_r :
                          (ssum_c[24] ? 24'hFFFFFF : ssum_c[23:0]);
    res.total_length_mm = !seg_r ? sum_len_r :
                          (lsum_c[32] ? 32'hFFFFFFFF : lsum_c[31:0]);
    res.is_last         = word_r.route_end;
  end

endmodule

FILE: hw/rtl/wtsg_ctrl.sv
module wtsg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  wtsg_pkg::wtsg_sts_t sts,
  output wtsg_pkg::wtsg_cmd_t cmd
);
  import wtsg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_SQX, S_SQY, S_CALC, S_MUL1, S_MUL2, S_DIVI, S_DIV, S_FIN, S_EMIT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_CHK;
        S_CHK:  state_r <= sts.seg ? S_SQX : S_EMIT;
        S_SQX:  state_r <= S_SQY;
        S_SQY: begin
          state_r <= S_CALC;
          cnt_r   <= '0;
        end
        S_CALC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(CALC_N - 1)) state_r <= S_MUL1;
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_DIVI;
        S_DIVI: begin
          state_r <= S_DIV;
          cnt_r   <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DVD_W - 1)) state_r <= S_FIN;
        end
        S_FIN:  state_r <= S_EMIT;
        S_EMIT: if (!sts.need_out || out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd           = '0;
    cmd.idx       = cnt_r;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.sq_x      = (state_r == S_SQX);
    cmd.sq_y      = (state_r == S_SQY);
    cmd.calc_step = (state_r == S_CALC);
    cmd.mul1      = (state_r == S_MUL1);
    cmd.mul2      = (state_r == S_MUL2);
    cmd.div_init  = (state_r == S_DIVI);
    cmd.div_step  = (state_r == S_DIV);
    cmd.finish    = (state_r == S_FIN);
    cmd.emit      = (state_r == S_EMIT) && (!sts.need_out || out_free);
  end

endmodule

FILE: hw/rtl/waypoint_turn_and_step_guidance.sv
// Waypoint turn-and-step guidance.
// Input channel (in_valid/in_ready/in_word): one waypoint word per handshake.
// Result channel (out_valid/out_ready/out_word): zero or one result word per
// waypoint; a result comes for every new segment and for every route end.
// Config: APB-style port, map scale at 0x0, step_length_mm at 0x4.
// A repeated or first point goes from the check state straight to emit; a
// new segment runs through the shared bit-serial square root / CORDIC loop
// and then the restoring stride divider before out_valid. One waypoint is
// processed at a time; in_ready is high only while the sequencer is idle,
// so a new waypoint is not taken before the last one is through.
// The result sits in an output register, so the next waypoint is accepted
// while a result waits; if the receiver stalls, the block holds its next
// result until the register frees.
// Reset clears route state and totals and loads the register defaults
// (scale 1.0, stride 700 mm).
module waypoint_turn_and_step_guidance (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wtsg_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output wtsg_pkg::out_word_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import wtsg_pkg::*;

  logic [SCALE_W-1:0]  scale_r;
  logic [STRIDE_W-1:0] stride_r;
  logic                out_valid_r;
  out_word_t           out_word_r;
  wtsg_cmd_t           cmd;
  wtsg_sts_t           sts;
  out_word_t           res;
  logic                out_free;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_STRIDE) ? {20'b0, stride_r} : {8'b0, scale_r};
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RST;
      stride_r <= STRIDE_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SCALE) begin
        scale_r <= pwdata[SCALE_W-1:0];
      end else begin
        stride_r <= pwdata[STRIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && sts.need_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && sts.need_out) out_word_r <= res;
  end

  wtsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  wtsg_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_word        (in_word),
    .map_scale      (scale_r),
    .step_length_mm (stride_r),
    .sts            (sts),
    .res            (res)
  );

endmodule
